// File: hdl/mpbf_pkg.sv
// ----------------------------------------------------------------------------
// mpbf_pkg
// Types and codes shared by the multi-pipe byte FIFO pool.
// ----------------------------------------------------------------------------
package mpbf_pkg;

  localparam int unsigned PIPE_IDX_W = 2;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned ADDRESSABLE_PIPES = 4;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FREE      = 3'd1;
  localparam logic [2:0] ST_NONE_LEFT = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]            operation;
    logic [PIPE_IDX_W-1:0] pipe_index;
    logic [7:0]            write_byte;
    logic                  last_of_transfer;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            result_status;
    logic [7:0]            read_byte;
    logic [PIPE_IDX_W-1:0] allocated_index;
    logic [FILL_W-1:0]     fill_level;
    logic                  wake_readers;
    logic                  wake_writers;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: hdl/mpbf_store.sv
// ----------------------------------------------------------------------------
// mpbf_store
// Byte storage shared by all pipes, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module mpbf_store
  import mpbf_pkg::*;
#(
  parameter int unsigned WORDS  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  mem_ctl_t          mem_ctl_i,
  input  logic [ADDR_W-1:0] mem_addr_i,
  input  logic [7:0]        mem_wdata_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [WORDS];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem[mem_addr_i] <= mem_wdata_i;
    end
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem[mem_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/mpbf_ctrl.sv
// ----------------------------------------------------------------------------
// mpbf_ctrl
// Pipe allocation, pointer and count state, and the result of each operation.
// ----------------------------------------------------------------------------
module mpbf_ctrl
  import mpbf_pkg::*;
#(
  parameter int unsigned NACT       = 4,
  parameter int unsigned PIPE_DEPTH = 16,
  parameter int unsigned ADDR_W     = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  in_item_t          item_i,
  output out_item_t         result_o,
  output mem_ctl_t          mem_ctl_o,
  output logic [ADDR_W-1:0] mem_addr_o,
  output logic [7:0]        mem_wdata_o
);

  localparam int unsigned IDX_W = (NACT > 1) ? $clog2(NACT) : 1;
  localparam int unsigned PTR_W = $clog2(PIPE_DEPTH);
  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PIPE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIPE_DEPTH);
  localparam logic [PIPE_IDX_W:0] NACT_LIM = (PIPE_IDX_W + 1)'(NACT);

  logic             in_use_q [NACT];
  logic             in_use_d [NACT];
  logic [PTR_W-1:0] wp_q     [NACT];
  logic [PTR_W-1:0] wp_d     [NACT];
  logic [PTR_W-1:0] rp_q     [NACT];
  logic [PTR_W-1:0] rp_d     [NACT];
  logic [CNT_W-1:0] cnt_q    [NACT];
  logic [CNT_W-1:0] cnt_d    [NACT];

  logic             pipe_ok;
  logic [IDX_W-1:0] sel;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [PTR_W-1:0] ptr;
  logic             found;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NACT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign sel     = item_i.pipe_index[IDX_W-1:0];
  assign pipe_ok = ({1'b0, item_i.pipe_index} < NACT_LIM) && in_use_q[sel];
  assign cnt     = cnt_q[sel];
  assign ptr     = (item_i.operation == OP_READ) ? rp_q[sel] : wp_q[sel];

  assign mem_addr_o  = ADDR_W'(sel) * ADDR_W'(PIPE_DEPTH) + ADDR_W'(ptr);
  assign mem_wdata_o = item_i.write_byte;

  always_comb begin
    in_use_d  = in_use_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    result_o  = '0;
    mem_ctl_o = '0;
    cnt_next  = cnt;
    if (item_i.operation == OP_CREATE) begin
      if (found) begin
        in_use_d[free_idx]       = 1'b1;
        result_o.allocated_index = PIPE_IDX_W'(free_idx);
      end else begin
        result_o.result_status = ST_NONE_LEFT;
      end
    end else if (!pipe_ok) begin
      result_o.result_status = ST_FREE;
    end else begin
      unique case (item_i.operation) inside
        OP_CREATE, OP_DESTROY: begin
          in_use_d[sel]         = 1'b0;
          wp_d[sel]             = '0;
          rp_d[sel]             = '0;
          cnt_d[sel]            = '0;
          result_o.wake_readers = 1'b1;
          result_o.wake_writers = 1'b1;
        end
        OP_WRITE: begin
          if (cnt == CNT_FULL) begin
            result_o.result_status = ST_FULL;
            result_o.wake_readers  = 1'b1;
          end else begin
            cnt_next              = cnt + 1'b1;
            mem_ctl_o.wr_en       = 1'b1;
            wp_d[sel]             = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
            cnt_d[sel]            = cnt_next;
            result_o.wake_readers = item_i.last_of_transfer || (cnt_next == CNT_FULL);
          end
          result_o.fill_level = FILL_W'(cnt_next);
        end
        OP_READ: begin
          if (cnt == '0) begin
            result_o.result_status = ST_EMPTY;
            result_o.wake_writers  = 1'b1;
          end else begin
            cnt_next              = cnt - 1'b1;
            mem_ctl_o.rd_en       = 1'b1;
            rp_d[sel]             = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
            cnt_d[sel]            = cnt_next;
            result_o.wake_writers = item_i.last_of_transfer || (cnt_next == '0);
          end
          result_o.fill_level = FILL_W'(cnt_next);
        end
      endcase
    end
    if (!accept_i) begin
      mem_ctl_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NACT; i++) begin
        in_use_q[i] <= 1'b0;
        wp_q[i]     <= '0;
        rp_q[i]     <= '0;
        cnt_q[i]    <= '0;
      end
    end else if (accept_i) begin
      in_use_q <= in_use_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/multi_pipe_byte_fifo_pool_core.sv
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_pool_core
// A pool of small circular byte FIFOs driven by create, destroy, write and
// read operations, one result item for every operation item.
// ----------------------------------------------------------------------------
// Each input item carries one operation. It is taken when in_valid_i is high
// and in_stall_o is low; the result item appears on out_item_o in the next
// cycle with out_valid_o high and stays until out_stall_i is low at a clock
// edge. The pipe state is updated and the byte store is accessed at the edge
// that accepts an item, and the store's registered read port delivers the
// popped byte together with the rest of the result.
// A new item may be accepted in every cycle, also while a result is being
// taken. While the receiver stalls a waiting result, in_stall_o is raised and
// no further item is taken. Reset frees every pipe and empties it; the byte
// store is not cleared, since a byte is only read after it has been written.
// Only pipes below both PIPE_COUNT and four can be allocated or addressed.
// ----------------------------------------------------------------------------
module multi_pipe_byte_fifo_pool_core
  import mpbf_pkg::*;
#(
  parameter int unsigned PIPE_COUNT = 4,
  parameter int unsigned PIPE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned NACT =
    (PIPE_COUNT < ADDRESSABLE_PIPES) ? PIPE_COUNT : ADDRESSABLE_PIPES;
  localparam int unsigned WORDS  = NACT * PIPE_DEPTH;
  localparam int unsigned ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic              accept;
  logic              valid_q;
  logic              rd_ok_q;
  out_item_t         res_q;
  out_item_t         result;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        rd_data;

  assign in_stall_o = valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  mpbf_ctrl #(
    .NACT       (NACT),
    .PIPE_DEPTH (PIPE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .result_o    (result),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  mpbf_store #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i       (clk_i),
    .mem_ctl_i   (mem_ctl),
    .mem_addr_i  (mem_addr),
    .mem_wdata_i (mem_wdata),
    .rd_data_o   (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q   <= result;
      rd_ok_q <= mem_ctl.rd_en;
    end
  end

  always_comb begin
    out_item_o = res_q;
    if (rd_ok_q) begin
      out_item_o.read_byte = rd_data;
    end
  end

  assign out_valid_o = valid_q;

endmodule
